// ===== sv/lpfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lowpass and feedback comb package
// Shared widths, register reset values, register indexes and the saturation
// function of the lowpass and feedback comb block.
// ----------------------------------------------------------------------------
package lpfc_pkg;

   localparam int SAMPLE_W = 16;
   localparam int ALPHA_W  = 16;
   localparam int GAIN_W   = 15;
   localparam int DELAY_W  = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Width used for sums before saturation.
   localparam int WIDE_W = SAMPLE_W + 3;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd3277;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 16'd32768;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 15'd13107;
   localparam logic [DELAY_W-1:0] DELAY_RESET = 11'd1000;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [WIDE_W-1:0]   wide_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SMOOTHING_ALPHA = 2'd0,
      CSR_FEEDBACK_GAIN   = 2'd1,
      CSR_DELAY_LENGTH    = 2'd2
   } csr_reg_type;

   function automatic sample_type sat_sample(input wide_type v);
      sample_type r;
      if (v > wide_type'(32767)) begin
         r = 16'sh7fff;
      end else if (v < -wide_type'(32768)) begin
         r = 16'sh8000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/lpfc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered and holds
// while no read is requested. A read of the address being written returns
// the old contents.
// ----------------------------------------------------------------------------
module lpfc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== sv/lowpass_then_feedback_comb.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lowpass then feedback comb
// One-pole lowpass on signed Q1.15 samples followed by a feedback comb whose
// delay line sits in a RAM of DELAY_DEPTH entries.
//
// Samples enter on the req_ channel and results leave on the rsp_ channel;
// each is a valid/ready transfer, one result for every sample.
// The csr_ port writes smoothing alpha, feedback gain and delay length; it
// is to be written only while no sample is in flight; the block does not enforce it.
// An accepted sample is registered into the comb stage and then into the
// output register that drives rsp_: on acceptance the lowpass is computed
// and the delay RAM read; as the comb stage advances it reads back the
// delayed sample, forms the feedback value and writes it to the RAM.
// One sample is accepted every cycle while the receiver does not stall; the
// lowpass state and the RAM port, each used once per sample, set that rate.
// Reset is immediate: the delay line is tracked by a fill pointer and a wrap
// flag, so entries not yet written read as zero and no clearing pass runs.
// When the receiver stalls, the result stays in the output register and the
// middle stage holds; once both are full, req_ready drops.
// ----------------------------------------------------------------------------
module lowpass_then_feedback_comb
   import lpfc_pkg::*;
#(
   parameter int DELAY_DEPTH = 1024
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic signed [15:0]     req_sample_in,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic signed [15:0]          rsp_sample_out,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int DW = $clog2(DELAY_DEPTH + 1);
   localparam int XW = (DW > DELAY_W) ? DW : DELAY_W;
   localparam int PW = 2 * SAMPLE_W + 2;

   logic [ALPHA_W-1:0] alpha_ff;
   logic [GAIN_W-1:0]  gain_ff;
   logic [DELAY_W-1:0] delay_ff;

   sample_type         lp_prev_ff;
   logic [AW-1:0]      pos_ff;
   logic [AW-1:0]      pos_in;
   logic               wrapped_ff;

   logic               s1_valid_ff;
   sample_type         s1_y_ff;
   logic [AW-1:0]      s1_addr_ff;
   logic               s1_written_ff;
   logic               s1_fwd_ff;
   sample_type         s1_fwd_data_ff;

   logic               rsp_valid_ff;
   sample_type         rsp_sample_ff;

   logic               out_can_load;
   logic               s1_adv;
   logic               accept;

   logic [ALPHA_W:0]          alpha_eff;
   logic signed [SAMPLE_W:0]  lp_diff;
   logic signed [PW-1:0]      lp_prod;
   logic signed [PW-1:0]      lp_sum;
   sample_type                lp_y;

   logic [XW-1:0]      dl_x;
   logic [DW-1:0]      dl_eff;
   logic [DW-1:0]      pos_d;
   logic [DW-1:0]      rd_diff;
   logic [DW-1:0]      rd_addr_d;
   logic [AW-1:0]      rd_addr;
   logic               written_in;
   logic               fwd_hit;

   logic [SAMPLE_W-1:0]          ram_q;
   sample_type                   dly;
   sample_type                   dly_half;
   logic signed [2*SAMPLE_W-1:0] fb_prod;
   logic signed [2*SAMPLE_W-1:0] fb_sum;
   sample_type                   comb_o;
   sample_type                   comb_w;

   // Handshake and stage control.
   assign out_can_load = !rsp_valid_ff || rsp_ready;
   assign s1_adv       = s1_valid_ff && out_can_load;
   assign req_ready    = !s1_valid_ff || out_can_load;
   assign accept       = req_valid && req_ready;

   // Lowpass: prev + alpha * (x - prev), rounded half up.
   assign alpha_eff = (alpha_ff > ALPHA_ONE) ? {1'b0, ALPHA_ONE} : {1'b0, alpha_ff};
   assign lp_diff   = (SAMPLE_W + 1)'(req_sample_in) - (SAMPLE_W + 1)'(lp_prev_ff);
   assign lp_prod   = $signed(alpha_eff) * lp_diff;
   assign lp_sum    = (PW'(lp_prev_ff) <<< 15) + lp_prod + PW'(16384);
   assign lp_y      = sat_sample(wide_type'($signed(lp_sum[PW-1:15])));

   // Delay line read address, with the delay clamped to 1..DELAY_DEPTH.
   always_comb begin
      dl_x = XW'(delay_ff);
      if (dl_x == '0) begin
         dl_eff = DW'(1);
      end else if (dl_x > XW'(DELAY_DEPTH)) begin
         dl_eff = DW'(DELAY_DEPTH);
      end else begin
         dl_eff = dl_x[DW-1:0];
      end
   end

   assign pos_d     = DW'(pos_ff);
   assign rd_diff   = pos_d - dl_eff;
   assign rd_addr_d = (pos_d >= dl_eff) ? rd_diff : rd_diff + DW'(DELAY_DEPTH);
   assign rd_addr   = rd_addr_d[AW-1:0];
   assign written_in = wrapped_ff || (rd_addr < pos_ff);
   assign fwd_hit    = s1_adv && (s1_addr_ff == rd_addr);
   assign pos_in     = (pos_ff == AW'(DELAY_DEPTH - 1)) ? '0 : pos_ff + AW'(1);

   lpfc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DELAY_DEPTH)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (comb_w),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Comb stage.
   always_comb begin
      if (s1_fwd_ff) begin
         dly = s1_fwd_data_ff;
      end else if (s1_written_ff) begin
         dly = $signed(ram_q);
      end else begin
         dly = '0;
      end
   end

   assign dly_half = dly >>> 1;
   assign fb_prod  = dly * $signed({1'b0, gain_ff});
   assign fb_sum   = fb_prod + (2 * SAMPLE_W)'(16384);
   assign comb_o   = sat_sample(wide_type'(s1_y_ff) + wide_type'(dly_half));
   assign comb_w   = sat_sample(wide_type'(s1_y_ff)
                                + wide_type'($signed(fb_sum[2*SAMPLE_W-1:15])));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         gain_ff  <= GAIN_RESET;
         delay_ff <= DELAY_RESET;
      end else if (csr_write_en) begin
         case (csr_reg_type'(csr_index))
            CSR_SMOOTHING_ALPHA: begin
               alpha_ff <= csr_wdata[ALPHA_W-1:0];
            end
            CSR_FEEDBACK_GAIN: begin
               gain_ff <= csr_wdata[GAIN_W-1:0];
            end
            CSR_DELAY_LENGTH: begin
               delay_ff <= csr_wdata[DELAY_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Filter state and stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         lp_prev_ff   <= '0;
         pos_ff       <= '0;
         wrapped_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            lp_prev_ff <= lp_y;
            pos_ff     <= pos_in;
            if (pos_ff == AW'(DELAY_DEPTH - 1)) begin
               wrapped_ff <= 1'b1;
            end
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_y_ff        <= lp_y;
         s1_addr_ff     <= pos_ff;
         s1_written_ff  <= written_in;
         s1_fwd_ff      <= fwd_hit;
         s1_fwd_data_ff <= comb_w;
      end
      if (s1_adv) begin
         rsp_sample_ff <= comb_o;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

`ifndef SYNTHESIS
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_can_load) |-> !req_ready)
      else $error("input taken while the comb stage is stalled");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted sample did not reach the comb stage");

   a_stage_fills_output: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("comb stage result did not reach the output register");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= AW'(DELAY_DEPTH - 1))
      else $error("write position beyond the delay line");

   a_wrap_sticky: assert property (@(posedge clock) disable iff (reset)
      wrapped_ff |=> wrapped_ff)
      else $error("wrap flag cleared without reset");
`endif

endmodule
`default_nettype wire
